// File: rtl/core/rcog_pkg.sv
`default_nettype none
package rcog_pkg;

  // coordinate width that covers the largest grid side
  localparam int CRD_W = 12;

  localparam logic [1:0] REQ_KEY   = 2'd0;
  localparam logic [1:0] REQ_POINT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic [1:0] OP_REPORT = 2'd0;
  localparam logic [1:0] OP_POINT  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] CLS_FREE    = 2'd0;
  localparam logic [1:0] CLS_UNKNOWN = 2'd1;
  localparam logic [1:0] CLS_OCC     = 2'd2;

  localparam logic [2:0] REG_CPM       = 3'd0;
  localparam logic [2:0] REG_ORG_COL   = 3'd1;
  localparam logic [2:0] REG_ORG_ROW   = 3'd2;
  localparam logic [2:0] REG_NORM_COL  = 3'd3;
  localparam logic [2:0] REG_NORM_ROW  = 3'd4;
  localparam logic [2:0] REG_MIN_VIS   = 3'd5;
  localparam logic [2:0] REG_FREE_LVL  = 3'd6;
  localparam logic [2:0] REG_OCC_LVL   = 3'd7;

  localparam logic [6:0]  PCT_UNKNOWN = 7'd50;
  localparam logic [22:0] PCT_SCALE   = 23'd100;
  localparam logic [15:0] CNT_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_z;
    logic               ground_flag;
    logic [6:0]         cell_row;
    logic [7:0]         cell_col;
  } in_t;

  typedef struct packed {
    logic       accepted;
    logic [1:0] cell_class;
    logic [6:0] occupancy_percent;
    logic [15:0] visit_total;
    logic [15:0] occupied_total;
  } out_t;

  typedef struct packed {
    logic [15:0]        cells_per_meter;
    logic signed [15:0] grid_origin_col;
    logic signed [15:0] grid_origin_row;
    logic [16:0]        norm_col;
    logic [16:0]        norm_row;
    logic [15:0]        min_visits;
    logic [8:0]         free_level;
    logic [8:0]         occupied_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             acc;
    logic             ground;
    logic [CRD_W-1:0] key_col;
    logic [CRD_W-1:0] key_row;
    logic [CRD_W-1:0] col;
    logic [CRD_W-1:0] row;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/rcog_ram.sv
`default_nettype none
module rcog_ram #(
  parameter int W = 16,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

// File: rtl/core/rcog_fifo.sv
`default_nettype none
module rcog_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rcog_pkg::cmd_t push_data,
  input  logic          pop,
  output rcog_pkg::cmd_t head,
  output logic          full,
  output logic          empty
);
  import rcog_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = wp_r + 1'b1;
    end
    if (pop && !empty) begin
      rp_nxt = rp_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/rcog_front.sv
`default_nettype none
module rcog_front #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  rcog_pkg::in_t  in_data,
  input  rcog_pkg::cfg_t cfg,
  input  logic           hold,
  output logic           busy,
  input  logic           q_full,
  output logic           q_push,
  output rcog_pkg::cmd_t q_data
);
  import rcog_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_S    = 3'd1;
  localparam logic [2:0] F_D    = 3'd2;
  localparam logic [2:0] F_LO   = 3'd3;
  localparam logic [2:0] F_HI   = 3'd4;
  localparam logic [2:0] F_PUSH = 3'd5;

  logic [2:0]         st_r, st_nxt;
  logic               axis_r, axis_nxt;
  in_t                item_r, item_nxt;
  logic signed [48:0] s_r, s_nxt;
  logic signed [49:0] d_r, d_nxt;
  logic [16:0]        plo_r, plo_nxt;
  logic [CRD_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic               cok_r, cok_nxt, rok_r, rok_nxt;
  logic [CRD_W-1:0]   kcol_r, kcol_nxt, krow_r, krow_nxt;
  logic               kval_r, kval_nxt;

  logic signed [48:0] pos_s, cpm_s;
  logic signed [49:0] s_ext, org_s, d_calc;
  logic [16:0]        norm_sel;
  logic [40:0]        lo_prod;
  logic [41:0]        hi_t;
  logic [25:0]        cq, lim;
  logic               q_ok, rd_in, ready;
  logic [CRD_W-1:0]   q_cell;

  assign ready  = (st_r == F_IDLE) && !hold;
  assign busy   = !ready;
  assign pos_s  = axis_r ? item_r.pos_z : item_r.pos_x;
  assign cpm_s  = {33'd0, cfg.cells_per_meter};
  assign s_ext  = s_r;
  assign org_s  = axis_r ? cfg.grid_origin_row : cfg.grid_origin_col;
  assign d_calc = s_ext - (org_s <<< 24);
  assign norm_sel = axis_r ? cfg.norm_row : cfg.norm_col;
  assign lo_prod  = 41'(d_r[23:0]) * 41'(norm_sel);
  assign hi_t     = 42'(d_r[47:24]) * 42'(norm_sel) + 42'(plo_r);
  assign cq       = hi_t[41:16];
  assign lim      = axis_r ? 26'(GRID_H) : 26'(GRID_W);
  // zero scale maps every position to cell zero
  assign q_ok     = (norm_sel == 17'd0) || (!d_r[49] && (cq < lim));
  assign q_cell   = (norm_sel == 17'd0) ? '0 : cq[CRD_W-1:0];
  assign rd_in    = (32'(item_r.cell_row) < 32'(GRID_H)) &&
                    (32'(item_r.cell_col) < 32'(GRID_W));

  always_comb begin
    st_nxt   = st_r;
    axis_nxt = axis_r;
    item_nxt = item_r;
    s_nxt    = s_r;
    d_nxt    = d_r;
    plo_nxt  = plo_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    cok_nxt  = cok_r;
    rok_nxt  = rok_r;
    kcol_nxt = kcol_r;
    krow_nxt = krow_r;
    kval_nxt = kval_r;
    q_push   = 1'b0;
    q_data   = '0;
    unique case (st_r)
      F_IDLE: begin
        if (start && ready) begin
          item_nxt = in_data;
          axis_nxt = 1'b0;
          if (in_data.req_type == REQ_KEY || in_data.req_type == REQ_POINT) begin
            st_nxt = F_S;
          end else begin
            st_nxt = F_PUSH;
          end
        end
      end
      F_S: begin
        s_nxt  = pos_s * cpm_s;
        st_nxt = F_D;
      end
      F_D: begin
        d_nxt  = d_calc;
        st_nxt = F_LO;
      end
      F_LO: begin
        plo_nxt = lo_prod[40:24];
        st_nxt  = F_HI;
      end
      F_HI: begin
        if (axis_r) begin
          row_nxt = q_cell;
          rok_nxt = q_ok;
          st_nxt  = F_PUSH;
        end else begin
          col_nxt  = q_cell;
          cok_nxt  = q_ok;
          axis_nxt = 1'b1;
          st_nxt   = F_S;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          st_nxt = F_IDLE;
          unique case (item_r.req_type)
            REQ_KEY: begin
              q_data.op  = OP_REPORT;
              q_data.acc = cok_r && rok_r;
              kval_nxt   = cok_r && rok_r;
              if (cok_r && rok_r) begin
                kcol_nxt = col_r;
                krow_nxt = row_r;
              end
            end
            REQ_POINT: begin
              if (kval_r && cok_r && rok_r) begin
                q_data.op      = OP_POINT;
                q_data.acc     = 1'b1;
                q_data.ground  = item_r.ground_flag;
                q_data.key_col = kcol_r;
                q_data.key_row = krow_r;
                q_data.col     = col_r;
                q_data.row     = row_r;
              end else begin
                q_data.op = OP_REPORT;
              end
            end
            REQ_READ: begin
              if (rd_in) begin
                q_data.op  = OP_READ;
                q_data.acc = 1'b1;
                q_data.col = CRD_W'(item_r.cell_col);
                q_data.row = CRD_W'(item_r.cell_row);
              end else begin
                q_data.op = OP_REPORT;
              end
            end
            REQ_CLEAR: begin
              q_data.op  = OP_CLEAR;
              q_data.acc = 1'b1;
            end
          endcase
        end
      end
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      axis_r <= 1'b0;
      cok_r  <= 1'b0;
      rok_r  <= 1'b0;
      kcol_r <= '0;
      krow_r <= '0;
      kval_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      axis_r <= axis_nxt;
      cok_r  <= cok_nxt;
      rok_r  <= rok_nxt;
      kcol_r <= kcol_nxt;
      krow_r <= krow_nxt;
      kval_r <= kval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    s_r    <= s_nxt;
    d_r    <= d_nxt;
    plo_r  <= plo_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
  end
endmodule
`default_nettype wire

// File: rtl/core/rcog_back.sv
`default_nettype none
module rcog_back #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rcog_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  rcog_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           init_busy,
  output logic           out_valid,
  output rcog_pkg::out_t out_data
);
  import rcog_pkg::*;

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = CRD_W + 2;
  localparam int EW = SW + 2;

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_CLR  = 4'd1;
  localparam logic [3:0] B_PRD  = 4'd2;
  localparam logic [3:0] B_PWR  = 4'd3;
  localparam logic [3:0] B_WSET = 4'd4;
  localparam logic [3:0] B_WADR = 4'd5;
  localparam logic [3:0] B_WRD  = 4'd6;
  localparam logic [3:0] B_WWR  = 4'd7;
  localparam logic [3:0] B_RRD  = 4'd8;
  localparam logic [3:0] B_RDAT = 4'd9;
  localparam logic [3:0] B_DIV  = 4'd10;
  localparam logic [3:0] B_CLS  = 4'd11;

  logic [3:0]          st_r, st_nxt;
  logic                init_r, init_nxt;
  logic [AW-1:0]       addr_r, addr_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic                osel_r, osel_nxt;
  logic signed [SW-1:0] bx_r, bx_nxt, bxe_r, bxe_nxt, by_r, by_nxt;
  logic signed [SW-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic                yneg_r, yneg_nxt, steep_r, steep_nxt;
  logic [15:0]         v_r, v_nxt, o_r, o_nxt, num_r, num_nxt, den_r, den_nxt;
  logic [22:0]         rem_r, rem_nxt;
  logic [6:0]          q_r, q_nxt;
  logic [2:0]          bit_r, bit_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_r, out_nxt;

  logic [15:0]          vis_rd, occ_rd, vis_wd, occ_wd, o_min;
  logic                 vis_we, occ_we;
  logic [AW-1:0]        head_addr, walk_addr;
  logic signed [SW-1:0] wx0, wy0, wx1, wy1, adx, ady, a0, b0, a1, b1;
  logic signed [SW-1:0] sa0, sb0, sa1, sb1, walk_row, walk_col;
  logic                 w_steep, w_swap, y_step;
  logic signed [EW-1:0] dx_e, dy_e, err_add;
  logic [22:0]          dv;
  logic [24:0]          num_sh, free_p, occ_p;
  logic [1:0]           cls;

  rcog_ram #(.W(16), .DEPTH(DEPTH)) u_vis (
    .clk(clk), .we(vis_we), .waddr(addr_r), .wdata(vis_wd), .raddr(addr_r), .rdata(vis_rd)
  );
  rcog_ram #(.W(16), .DEPTH(DEPTH)) u_occ (
    .clk(clk), .we(occ_we), .waddr(addr_r), .wdata(occ_wd), .raddr(addr_r), .rdata(occ_rd)
  );

  assign vis_we = (st_r == B_CLR) || (st_r == B_PWR && !osel_r) || (st_r == B_WWR);
  assign occ_we = (st_r == B_CLR) || (st_r == B_PWR && osel_r);
  // saturating increment
  assign vis_wd = (st_r == B_CLR) ? 16'd0 : ((vis_rd == CNT_MAX) ? vis_rd : vis_rd + 16'd1);
  assign occ_wd = (st_r == B_CLR) ? 16'd0 : ((occ_rd == CNT_MAX) ? occ_rd : occ_rd + 16'd1);

  assign head_addr = AW'(32'(q_head.row) * 32'(GRID_W) + 32'(q_head.col));
  assign walk_row  = steep_r ? bx_r : by_r;
  assign walk_col  = steep_r ? by_r : bx_r;
  assign walk_addr = AW'(32'(walk_row[CRD_W-1:0]) * 32'(GRID_W) +
                         32'(walk_col[CRD_W-1:0]));

  // line setup: swap axes when steep, then order endpoints along the major axis
  assign wx0 = {2'b00, cmd_r.key_col};
  assign wy0 = {2'b00, cmd_r.key_row};
  assign wx1 = {2'b00, cmd_r.col};
  assign wy1 = {2'b00, cmd_r.row};
  assign adx = (wx1 > wx0) ? wx1 - wx0 : wx0 - wx1;
  assign ady = (wy1 > wy0) ? wy1 - wy0 : wy0 - wy1;
  assign w_steep = ady > adx;
  assign a0 = w_steep ? wy0 : wx0;
  assign b0 = w_steep ? wx0 : wy0;
  assign a1 = w_steep ? wy1 : wx1;
  assign b1 = w_steep ? wx1 : wy1;
  assign w_swap = a0 > a1;
  assign sa0 = w_swap ? a1 : a0;
  assign sb0 = w_swap ? b1 : b0;
  assign sa1 = w_swap ? a0 : a1;
  assign sb1 = w_swap ? b0 : b1;

  assign dx_e    = dx_r;
  assign dy_e    = dy_r;
  assign err_add = err_r + (dy_e <<< 1);
  assign y_step  = err_add >= dx_e;

  assign o_min = (occ_rd > vis_rd) ? vis_rd : occ_rd;
  assign dv    = 23'(v_r) << bit_r;

  assign num_sh = {1'b0, num_r, 8'd0};
  assign free_p = 25'(cfg.free_level) * 25'(den_r);
  assign occ_p  = 25'(cfg.occupied_level) * 25'(den_r);
  assign cls    = (num_sh >= free_p) ? CLS_FREE : ((num_sh >= occ_p) ? CLS_UNKNOWN : CLS_OCC);

  assign q_pop     = (st_r == B_IDLE) && !q_empty;
  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    st_nxt    = st_r;
    init_nxt  = init_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    osel_nxt  = osel_r;
    bx_nxt    = bx_r;
    bxe_nxt   = bxe_r;
    by_nxt    = by_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    err_nxt   = err_r;
    yneg_nxt  = yneg_r;
    steep_nxt = steep_r;
    v_nxt     = v_r;
    o_nxt     = o_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    bit_nxt   = bit_r;
    out_valid_nxt = 1'b0;
    out_nxt   = out_r;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          cmd_nxt = q_head;
          unique case (q_head.op)
            OP_REPORT: begin
              out_valid_nxt    = 1'b1;
              out_nxt          = '0;
              out_nxt.accepted = q_head.acc;
            end
            OP_POINT: begin
              addr_nxt = head_addr;
              osel_nxt = !q_head.ground;
              st_nxt   = B_PRD;
            end
            OP_READ: begin
              addr_nxt = head_addr;
              st_nxt   = B_RRD;
            end
            OP_CLEAR: begin
              addr_nxt = '0;
              st_nxt   = B_CLR;
            end
          endcase
        end
      end
      B_CLR: begin
        if (addr_r == AW'(DEPTH - 1)) begin
          st_nxt   = B_IDLE;
          init_nxt = 1'b0;
          if (!init_r) begin
            out_valid_nxt    = 1'b1;
            out_nxt          = '0;
            out_nxt.accepted = 1'b1;
          end
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      B_PRD: st_nxt = B_PWR;
      B_PWR: st_nxt = B_WSET;
      B_WSET: begin
        steep_nxt = w_steep;
        bx_nxt    = sa0;
        bxe_nxt   = sa1;
        by_nxt    = sb0;
        dx_nxt    = sa1 - sa0;
        dy_nxt    = (sb1 > sb0) ? sb1 - sb0 : sb0 - sb1;
        yneg_nxt  = !(sb0 < sb1);
        err_nxt   = '0;
        st_nxt    = B_WADR;
      end
      B_WADR: begin
        addr_nxt = walk_addr;
        st_nxt   = B_WRD;
      end
      B_WRD: st_nxt = B_WWR;
      B_WWR: begin
        if (bx_r == bxe_r) begin
          st_nxt           = B_IDLE;
          out_valid_nxt    = 1'b1;
          out_nxt          = '0;
          out_nxt.accepted = 1'b1;
        end else begin
          bx_nxt = bx_r + SW'(1);
          if (y_step) begin
            by_nxt  = yneg_r ? by_r - SW'(1) : by_r + SW'(1);
            err_nxt = err_add - (dx_e <<< 1);
          end else begin
            err_nxt = err_add;
          end
          st_nxt = B_WADR;
        end
      end
      B_RRD: st_nxt = B_RDAT;
      B_RDAT: begin
        v_nxt = vis_rd;
        o_nxt = occ_rd;
        if (vis_rd <= cfg.min_visits) begin
          num_nxt = 16'd1;
          den_nxt = 16'd2;
          q_nxt   = PCT_UNKNOWN;
          st_nxt  = B_CLS;
        end else begin
          num_nxt = vis_rd - o_min;
          den_nxt = vis_rd;
          rem_nxt = 23'(o_min) * PCT_SCALE;
          q_nxt   = '0;
          bit_nxt = 3'd6;
          st_nxt  = B_DIV;
        end
      end
      B_DIV: begin
        // one quotient bit per cycle, quotient stays below 128
        if (rem_r >= dv) begin
          rem_nxt       = rem_r - dv;
          q_nxt[bit_r]  = 1'b1;
        end
        if (bit_r == 3'd0) begin
          st_nxt = B_CLS;
        end else begin
          bit_nxt = bit_r - 3'd1;
        end
      end
      B_CLS: begin
        out_valid_nxt             = 1'b1;
        out_nxt.accepted          = 1'b1;
        out_nxt.cell_class        = cls;
        out_nxt.occupancy_percent = q_r;
        out_nxt.visit_total       = v_r;
        out_nxt.occupied_total    = o_r;
        st_nxt                    = B_IDLE;
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_CLR;
      init_r      <= 1'b1;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      init_r      <= init_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    osel_r  <= osel_nxt;
    bx_r    <= bx_nxt;
    bxe_r   <= bxe_nxt;
    by_r    <= by_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    err_r   <= err_nxt;
    yneg_r  <= yneg_nxt;
    steep_r <= steep_nxt;
    v_r     <= v_nxt;
    o_r     <= o_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    bit_r   <= bit_nxt;
    out_r   <= out_nxt;
  end

`ifndef SYNTHESIS
  a_no_out_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> !out_valid_r) else $error("result during init clear");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_WWR) |-> (bx_r <= bxe_r)) else $error("walk passed its end");
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.occupancy_percent <= 7'd100)) else $error("percent out of range");
`endif
endmodule
`default_nettype wire

// File: rtl/core/ray_cast_occupancy_grid_top.sv
`default_nettype none
// Reads above the minimum visit count run the 7-step divider; points walk the line cell by cell.
// The front holds one request at a time, busy until it is queued; a 4-entry queue decouples it from the back.
// Clear: one counter entry per cycle over all GRID_W*GRID_H cells.
// Reset: synchronous; after reset a clear pass over all GRID_W*GRID_H cells holds busy high.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module ray_cast_occupancy_grid_top #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rcog_pkg::in_t  in_data,
  output logic           out_valid,
  output rcog_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import rcog_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic cfg_we, q_push, q_pop, q_full, q_empty, init_busy;
  cmd_t q_in, q_head;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (paddr[4:2])
        REG_CPM:      cfg_nxt.cells_per_meter = pwdata[15:0];
        REG_ORG_COL:  cfg_nxt.grid_origin_col = pwdata[15:0];
        REG_ORG_ROW:  cfg_nxt.grid_origin_row = pwdata[15:0];
        REG_NORM_COL: cfg_nxt.norm_col        = pwdata[16:0];
        REG_NORM_ROW: cfg_nxt.norm_row        = pwdata[16:0];
        REG_MIN_VIS:  cfg_nxt.min_visits      = pwdata[15:0];
        REG_FREE_LVL: cfg_nxt.free_level      = pwdata[8:0];
        REG_OCC_LVL:  cfg_nxt.occupied_level  = pwdata[8:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_CPM:      prdata = {16'd0, cfg_r.cells_per_meter};
      REG_ORG_COL:  prdata = {16'd0, cfg_r.grid_origin_col};
      REG_ORG_ROW:  prdata = {16'd0, cfg_r.grid_origin_row};
      REG_NORM_COL: prdata = {15'd0, cfg_r.norm_col};
      REG_NORM_ROW: prdata = {15'd0, cfg_r.norm_row};
      REG_MIN_VIS:  prdata = {16'd0, cfg_r.min_visits};
      REG_FREE_LVL: prdata = {23'd0, cfg_r.free_level};
      REG_OCC_LVL:  prdata = {23'd0, cfg_r.occupied_level};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cells_per_meter <= 16'd1280;
      cfg_r.grid_origin_col <= -16'sd50;
      cfg_r.grid_origin_row <= -16'sd25;
      cfg_r.norm_col        <= 17'd64880;
      cfg_r.norm_row        <= 17'd64912;
      cfg_r.min_visits      <= 16'd5;
      cfg_r.free_level      <= 9'd141;
      cfg_r.occupied_level  <= 9'd128;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rcog_front #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data), .cfg(cfg_r),
    .hold(init_busy), .busy(busy), .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  rcog_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .pop(q_pop),
    .head(q_head), .full(q_full), .empty(q_empty)
  );

  rcog_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_empty(q_empty), .q_head(q_head),
    .q_pop(q_pop), .init_busy(init_busy), .out_valid(out_valid), .out_data(out_data)
  );
endmodule
`default_nettype wire

// File: tb/sv/ray_cast_occupancy_grid_checker.sv
`timescale 1ns / 100ps
module ray_cast_occupancy_grid_checker
  import rcog_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_t         in_data,
  input  logic        out_valid,
  input  out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  localparam int GW = 256;
  localparam int GH = 128;

  cfg_t cfg;
  logic [15:0] visit_mem [GW*GH];
  logic [15:0] occ_mem [GW*GH];
  int  key_c, key_r;
  bit  key_ok;
  out_t result_q[$];

  function automatic bit to_cell(logic signed [31:0] pos, logic signed [15:0] org,
                                 logic [16:0] nrm, int lim, output int cell_no);
    longint s, d;
    longint unsigned hi, lo, t, c;
    s = longint'(pos) * longint'(cfg.cells_per_meter);
    d = s - longint'(org) * 64'sd16777216;
    if (nrm == 0) begin
      c = 0;
    end else begin
      if (d < 0) return 0;
      hi = longint'(d) >> 24;
      lo = d & 64'hFFFFFF;
      t = hi * nrm + ((lo * nrm) >> 24);
      c = t >> 16;
    end
    if (c >= lim) return 0;
    cell_no = int'(c);
    return 1;
  endfunction

  function automatic void inc_visit(int r, int c);
    if (r < 0 || r >= GH || c < 0 || c >= GW) return;
    if (visit_mem[r*GW+c] != CNT_MAX) visit_mem[r*GW+c] = visit_mem[r*GW+c] + 16'd1;
  endfunction

  function automatic void cast_ray(int x0, int y0, int x1, int y1);
    int adx, ady, t, dx, dy, err, y, ystep;
    bit steep;
    adx = x1 > x0 ? x1 - x0 : x0 - x1;
    ady = y1 > y0 ? y1 - y0 : y0 - y1;
    steep = ady > adx;
    if (steep) begin
      t = x0; x0 = y0; y0 = t;
      t = x1; x1 = y1; y1 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    dx = x1 - x0;
    dy = y1 > y0 ? y1 - y0 : y0 - y1;
    ystep = (y0 < y1) ? 1 : -1;
    err = 0;
    y = y0;
    for (int x = x0; x <= x1; x++) begin
      if (steep) inc_visit(x, y);
      else inc_visit(y, x);
      err += 2 * dy;
      if (err >= dx) begin
        y += ystep;
        err -= 2 * dx;
      end
    end
  endfunction

  function automatic out_t apply_request(in_t rq);
    out_t r;
    int c, w, i;
    longint unsigned v, o, num, den;
    r = '0;
    case (rq.req_type)
      REQ_KEY: begin
        if (to_cell(rq.pos_x, cfg.grid_origin_col, cfg.norm_col, GW, c) &&
            to_cell(rq.pos_z, cfg.grid_origin_row, cfg.norm_row, GH, w)) begin
          key_c = c;
          key_r = w;
          key_ok = 1;
          r.accepted = 1;
        end else begin
          key_ok = 0;
        end
      end
      REQ_POINT: begin
        if (key_ok &&
            to_cell(rq.pos_x, cfg.grid_origin_col, cfg.norm_col, GW, c) &&
            to_cell(rq.pos_z, cfg.grid_origin_row, cfg.norm_row, GH, w)) begin
          i = w * GW + c;
          if (rq.ground_flag) inc_visit(w, c);
          else if (occ_mem[i] != CNT_MAX) occ_mem[i] = occ_mem[i] + 16'd1;
          cast_ray(key_c, key_r, c, w);
          r.accepted = 1;
        end
      end
      REQ_READ: begin
        i = int'(rq.cell_row) * GW + int'(rq.cell_col);
        v = visit_mem[i];
        o = occ_mem[i];
        if (o > v) o = v;
        if (v <= cfg.min_visits) begin
          num = 1; den = 2;
          r.occupancy_percent = PCT_UNKNOWN;
        end else begin
          num = v - o; den = v;
          r.occupancy_percent = 7'((100 * o) / v);
        end
        if (num * 256 >= longint'(cfg.free_level) * den) r.cell_class = CLS_FREE;
        else if (num * 256 >= longint'(cfg.occupied_level) * den) r.cell_class = CLS_UNKNOWN;
        else r.cell_class = CLS_OCC;
        r.accepted = 1;
        r.visit_total = visit_mem[i];
        r.occupied_total = occ_mem[i];
      end
      default: begin
        foreach (visit_mem[k]) begin
          visit_mem[k] = '0;
          occ_mem[k] = '0;
        end
        r.accepted = 1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      cfg.cells_per_meter = 16'd1280;
      cfg.grid_origin_col = -16'sd50;
      cfg.grid_origin_row = -16'sd25;
      cfg.norm_col = 17'd64880;
      cfg.norm_row = 17'd64912;
      cfg.min_visits = 16'd5;
      cfg.free_level = 9'd141;
      cfg.occupied_level = 9'd128;
      foreach (visit_mem[k]) begin
        visit_mem[k] = '0;
        occ_mem[k] = '0;
      end
      key_c = 0;
      key_r = 0;
      key_ok = 0;
      result_q.delete();
      pending = 0;
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (result_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = result_q.pop_front();
          if (want.accepted != out_data.accepted ||
              want.cell_class != out_data.cell_class ||
              want.occupancy_percent != out_data.occupancy_percent ||
              want.visit_total != out_data.visit_total ||
              want.occupied_total != out_data.occupied_total) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p, got %p", want, out_data);
          end
        end
      end
      if (start && !busy) result_q.push_back(apply_request(in_data));
      pending = result_q.size();
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_CPM:      cfg.cells_per_meter = pwdata[15:0];
          REG_ORG_COL:  cfg.grid_origin_col = pwdata[15:0];
          REG_ORG_ROW:  cfg.grid_origin_row = pwdata[15:0];
          REG_NORM_COL: cfg.norm_col = pwdata[16:0];
          REG_NORM_ROW: cfg.norm_row = pwdata[16:0];
          REG_MIN_VIS:  cfg.min_visits = pwdata[15:0];
          REG_FREE_LVL: cfg.free_level = pwdata[8:0];
          default:      cfg.occupied_level = pwdata[8:0];
        endcase
      end
    end
  end
endmodule

// File: tb/sv/ray_cast_occupancy_grid_top_tb.sv
`timescale 1ns / 100ps
module ray_cast_occupancy_grid_top_tb;
  import rcog_pkg::*;

  localparam longint CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  longint      cycles = 0;

  int  reg_val [8];
  int  last_c, last_r;
  bit  no_gaps;

  ray_cast_occupancy_grid_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ray_cast_occupancy_grid_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // position that lands near cell c on one axis under the current registers
  function automatic logic [31:0] aim(bit row_axis, real c);
    real nrm, org, cpm, v;
    nrm = row_axis ? reg_val[REG_NORM_ROW] : reg_val[REG_NORM_COL];
    org = row_axis ? $itor($signed(16'(reg_val[REG_ORG_ROW])))
                   : $itor($signed(16'(reg_val[REG_ORG_COL])));
    cpm = reg_val[REG_CPM];
    if (nrm == 0) return $urandom;
    v = ((c * 65536.0 / nrm) + org) * 256.0 * 65536.0 / cpm;
    if (v > 2147483000.0) v = 2147483000.0;
    if (v < -2147483000.0) v = -2147483000.0;
    return $rtoi(v);
  endfunction

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return;
    if (r < 85) repeat ($urandom_range(1, 3)) @(negedge clk);
    else if (r < 97) repeat ($urandom_range(4, 15)) @(negedge clk);
    else repeat ($urandom_range(20, 200)) @(negedge clk);
  endtask

  task automatic issue(in_t rq);
    bit free;
    start <= 1'b1;
    in_data <= rq;
    forever begin
      @(posedge clk);
      free = !busy;
      @(negedge clk);
      if (free) break;
    end
    // posedge of the loop above sampled busy before the edge took effect
    if (!no_gaps && $urandom_range(0, 1)) begin
      start <= 1'b0;
      idle_gap();
    end
  endtask

  task automatic issue_req(logic [1:0] kind, real cx, real cz, bit gnd);
    in_t rq;
    rq = '0;
    rq.req_type = kind;
    rq.pos_x = aim(0, cx);
    rq.pos_z = aim(1, cz);
    rq.ground_flag = gnd;
    rq.cell_row = 7'($urandom);
    rq.cell_col = 8'($urandom);
    issue(rq);
  endtask

  task automatic issue_read(int r, int c);
    in_t rq;
    rq = '0;
    rq.req_type = REQ_READ;
    rq.pos_x = $urandom;
    rq.pos_z = $urandom;
    rq.cell_row = 7'(r);
    rq.cell_col = 8'(c);
    issue(rq);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int val);
    reg_val[idx] = val;
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_regs(int cpm, int oc, int orw, int nc, int nr, int mv, int fl, int ol);
    wait_idle();
    reg_write(REG_CPM, cpm);
    reg_write(REG_ORG_COL, oc & 16'hFFFF);
    reg_write(REG_ORG_ROW, orw & 16'hFFFF);
    reg_write(REG_NORM_COL, nc);
    reg_write(REG_NORM_ROW, nr);
    reg_write(REG_MIN_VIS, mv);
    reg_write(REG_FREE_LVL, fl);
    reg_write(REG_OCC_LVL, ol);
  endtask

  task automatic random_requests(int count);
    int r, c, w;
    in_t rq;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 999);
      if (r < 80) begin
        c = $urandom_range(0, 255);
        w = $urandom_range(0, 127);
        if ($urandom_range(0, 9) == 0) c = 300;
        if ($urandom_range(0, 19) == 0) w = -4;
        issue_req(REQ_KEY, c + 0.2 + 0.6 * $urandom_range(0, 100) / 100.0,
                  w + 0.2 + 0.6 * $urandom_range(0, 100) / 100.0, 0);
      end else if (r < 680) begin
        c = $urandom_range(0, 9) < 7 ? $urandom_range(0, 40) : $urandom_range(0, 255);
        w = $urandom_range(0, 9) < 7 ? $urandom_range(0, 30) : $urandom_range(0, 127);
        if ($urandom_range(0, 14) == 0) c = $urandom_range(0, 1) ? 260 : -3;
        if ($urandom_range(0, 14) == 0) w = $urandom_range(0, 1) ? 140 : -3;
        last_c = c;
        last_r = w;
        issue_req(REQ_POINT, c + 0.2 + 0.6 * $urandom_range(0, 100) / 100.0,
                  w + 0.2 + 0.6 * $urandom_range(0, 100) / 100.0, $urandom_range(0, 3) == 0);
      end else if (r < 930) begin
        if ($urandom_range(0, 1) && last_c >= 0 && last_c < 256 && last_r >= 0 && last_r < 128)
          issue_read(last_r, last_c);
        else if ($urandom_range(0, 1))
          issue_read($urandom_range(0, 30), $urandom_range(0, 40));
        else
          issue_read($urandom_range(0, 127), $urandom_range(0, 255));
      end else if (r < 934) begin
        issue_req(REQ_CLEAR, 0, 0, 1'($urandom));
      end else begin
        rq = $bits(in_t)'({$urandom, $urandom, $urandom});
        if (rq.req_type == REQ_CLEAR) rq.req_type = REQ_READ;
        issue(rq);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    no_gaps = 1'b0;
    last_c = 0;
    last_r = 0;
    reg_val[REG_CPM] = 1280;
    reg_val[REG_ORG_COL] = -50;
    reg_val[REG_ORG_ROW] = -25;
    reg_val[REG_NORM_COL] = 64880;
    reg_val[REG_NORM_ROW] = 64912;
    reg_val[REG_MIN_VIS] = 5;
    reg_val[REG_FREE_LVL] = 141;
    reg_val[REG_OCC_LVL] = 128;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: point with no keyframe, corners, out-of-grid keyframe and point, reads and a clear
    issue_req(REQ_POINT, 3.5, 3.5, 0);
    issue_req(REQ_KEY, 0.5, 0.5, 0);
    issue_req(REQ_POINT, 255.5, 127.5, 0);
    issue_req(REQ_POINT, 255.5, 0.5, 1);
    issue_req(REQ_POINT, 0.5, 127.5, 0);
    issue_req(REQ_POINT, 0.5, 0.5, 1);
    issue_req(REQ_POINT, -3.0, 10.5, 0);
    issue_req(REQ_POINT, 10.5, 200.0, 0);
    issue_read(0, 0);
    issue_read(127, 255);
    issue_read(0, 255);
    issue_read(64, 128);
    issue_req(REQ_KEY, 300.0, 5.5, 0);
    issue_req(REQ_POINT, 5.5, 5.5, 0);
    issue_req(REQ_KEY, 20.5, 20.5, 0);
    repeat (8) issue_req(REQ_POINT, 22.5, 21.5, 0);
    issue_read(21, 22);
    begin
      in_t rq;
      rq = '0;
      rq.req_type = REQ_KEY;
      rq.pos_x = 32'h7FFFFFFF;
      rq.pos_z = 32'h80000000;
      issue(rq);
    end
    issue_req(REQ_CLEAR, 0, 0, 0);
    issue_read(21, 22);

    no_gaps = 1'b1;
    random_requests(130);
    no_gaps = 1'b0;

    load_regs(1280, -50, -25, 64880, 64912, 5, 141, 128);
    random_requests(150);

    load_regs(65535, -32768, 32767, 65536, 1, 0, 256, 0);
    random_requests(130);

    load_regs(1280, -50, -25, 0, 0, 65535, 0, 256);
    issue_req(REQ_CLEAR, 0, 0, 0);
    random_requests(60);

    load_regs(1, -100, 10, 65536, 65536, 2, 200, 60);
    random_requests(150);

    load_regs(2560, -20, -40, 40000, 50000, 1, 180, 100);
    no_gaps = 1'b1;
    random_requests(60);
    no_gaps = 1'b0;
    random_requests(90);

    wait_idle();
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
